// ===== src/ntcot_pkg.sv =====
package ntcot_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int SEG_W      = 5;
    localparam int FRAC_W     = 7;
    localparam int TENTHS_W   = 12;
    localparam int SPAN_W     = 9;
    localparam int PROD_W     = SPAN_W + FRAC_W;
    localparam int MAG_W      = TENTHS_W - 1;
    localparam int DEG_W      = 9;
    localparam int REG_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 16;

    // divide by 10 as multiply by 2^16/10, exact for magnitudes up to 2047
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(6554);
    localparam int QPROD_W     = MAG_W + RECIP_W;
    localparam int QUOT_W      = QPROD_W - RECIP_SHIFT;

    localparam logic [REG_W-1:0] STREAK_MAX = '1;
    localparam logic [REG_W-1:0] TRIP_RESET = REG_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_LIMIT = 1'b0,
        CFG_TRIP_COUNT = 1'b1
    } cfg_index_t;

    typedef logic signed [TENTHS_W-1:0] tenths_t;

    // temperature table in tenths of a degree, 33 points, decreasing
    function automatic tenths_t tenths_rom(input logic [SEG_W:0] idx);
        tenths_t v;
        case (idx)
            6'd0:  v = 12'sd1835;
            6'd1:  v = 12'sd1493;
            6'd2:  v = 12'sd1151;
            6'd3:  v = 12'sd969;
            6'd4:  v = 12'sd847;
            6'd5:  v = 12'sd754;
            6'd6:  v = 12'sd678;
            6'd7:  v = 12'sd615;
            6'd8:  v = 12'sd560;
            6'd9:  v = 12'sd511;
            6'd10: v = 12'sd466;
            6'd11: v = 12'sd425;
            6'd12: v = 12'sd386;
            6'd13: v = 12'sd350;
            6'd14: v = 12'sd316;
            6'd15: v = 12'sd282;
            6'd16: v = 12'sd250;
            6'd17: v = 12'sd218;
            6'd18: v = 12'sd187;
            6'd19: v = 12'sd156;
            6'd20: v = 12'sd125;
            6'd21: v = 12'sd93;
            6'd22: v = 12'sd61;
            6'd23: v = 12'sd28;
            6'd24: v = -12'sd6;
            6'd25: v = -12'sd43;
            6'd26: v = -12'sd83;
            6'd27: v = -12'sd126;
            6'd28: v = -12'sd176;
            6'd29: v = -12'sd235;
            6'd30: v = -12'sd311;
            6'd31: v = -12'sd428;
            6'd32: v = -12'sd545;
            default: v = -12'sd545;
        endcase
        return v;
    endfunction

endpackage

// ===== src/ntc_overtemp_monitor_unit.sv =====
// Thermistor over-temperature monitor. Each input beat carries one 12-bit
// converter sample; the block looks it up in a 33-point temperature table,
// interpolates between table points, converts to whole degrees and checks it
// against temp_limit (zero turns the check off). Consecutive over-limit samples
// are counted, saturating at 255; once the count exceeds trip_count a sticky
// fault sets and stays set until reset, with alarm_pulse marking the sample
// that set it. One sample is taken every clock unless the output stalls; each
// result is presented from the last of three register stages (input register,
// interpolation register, result register), the interpolation multiply and the
// divide-by-ten multiply each having a stage of their own. Results come out in
// sample order, and m_tready low stalls the pipe only as far back as needed.
module ntc_overtemp_monitor_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wen,
    input  logic [ntcot_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ntcot_pkg::REG_W-1:0]           cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [11:0] adc_sample, [15:12] zero
    input  logic [ntcot_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [8:0] temperature_deg, [9] over_limit, [10] fault_latched,
    // [11] alarm_pulse, [15:12] zero
    output logic [ntcot_pkg::M_DATA_W-1:0]        m_tdata
);

    // configuration
    logic [ntcot_pkg::REG_W-1:0] temp_limit_reg;
    logic [ntcot_pkg::REG_W-1:0] trip_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_limit_reg <= '0;
            trip_count_reg <= ntcot_pkg::TRIP_RESET;
        end else if (cfg_wen) begin
            case (ntcot_pkg::cfg_index_t'(cfg_index))
                ntcot_pkg::CFG_TEMP_LIMIT: temp_limit_reg <= cfg_wdata;
                ntcot_pkg::CFG_TRIP_COUNT: trip_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic in_valid_reg;
    logic mid_valid_reg;
    logic out_valid_reg;
    logic out_adv;
    logic mid_adv;
    logic in_adv;

    assign out_adv  = !out_valid_reg || m_tready;
    assign mid_adv  = !mid_valid_reg || out_adv;
    assign in_adv   = !in_valid_reg || mid_adv;
    assign s_tready = in_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_adv)  in_valid_reg  <= s_tvalid;
            if (mid_adv) mid_valid_reg <= in_valid_reg;
            if (out_adv) out_valid_reg <= mid_valid_reg;
        end
    end

    // stage 1: sample register
    logic [ntcot_pkg::SAMPLE_W-1:0] sample_reg;

    always_ff @(posedge aclk) begin
        if (in_adv && s_tvalid) begin
            sample_reg <= s_tdata[ntcot_pkg::SAMPLE_W-1:0];
        end
    end

    // stage 2: table lookup and interpolation
    logic [ntcot_pkg::SEG_W-1:0]  seg;
    logic [ntcot_pkg::FRAC_W-1:0] frac;
    ntcot_pkg::tenths_t           lo_pt;
    ntcot_pkg::tenths_t           hi_pt;
    ntcot_pkg::tenths_t           span_full;
    logic [ntcot_pkg::SPAN_W-1:0] span;
    logic [ntcot_pkg::PROD_W-1:0] prod;
    ntcot_pkg::tenths_t           tenths_next;
    ntcot_pkg::tenths_t           tenths_reg;

    always_comb begin
        seg         = sample_reg[ntcot_pkg::SAMPLE_W-1:ntcot_pkg::FRAC_W];
        frac        = sample_reg[ntcot_pkg::FRAC_W-1:0];
        lo_pt       = ntcot_pkg::tenths_rom({1'b0, seg});
        hi_pt       = ntcot_pkg::tenths_rom({1'b0, seg} + 6'd1);
        // table decreases, so the span is never negative
        span_full   = lo_pt - hi_pt;
        span        = span_full[ntcot_pkg::SPAN_W-1:0];
        prod        = ntcot_pkg::PROD_W'(span) * ntcot_pkg::PROD_W'(frac);
        tenths_next = lo_pt - ntcot_pkg::TENTHS_W'(prod >> ntcot_pkg::FRAC_W);
    end

    always_ff @(posedge aclk) begin
        if (mid_adv && in_valid_reg) begin
            tenths_reg <= tenths_next;
        end
    end

    // stage 3: whole degrees, limit check, streak and fault
    logic                            neg;
    logic [ntcot_pkg::MAG_W-1:0]     mag;
    ntcot_pkg::tenths_t              mag_full;
    logic [ntcot_pkg::QPROD_W-1:0]   qprod;
    logic [ntcot_pkg::QUOT_W-1:0]    quot;
    logic signed [ntcot_pkg::DEG_W-1:0] deg;
    logic signed [ntcot_pkg::DEG_W:0]   limit_s;
    logic                            over;
    logic [ntcot_pkg::REG_W-1:0]     streak_reg;
    logic [ntcot_pkg::REG_W-1:0]     streak_next;
    logic                            fault_reg;
    logic                            fault_next;
    logic                            trip;
    logic                            pulse;

    always_comb begin
        neg      = tenths_reg[ntcot_pkg::TENTHS_W-1];
        mag_full = neg ? -tenths_reg : tenths_reg;
        mag      = mag_full[ntcot_pkg::MAG_W-1:0];
        qprod    = ntcot_pkg::QPROD_W'(mag) * ntcot_pkg::QPROD_W'(ntcot_pkg::RECIP_TEN);
        quot     = qprod[ntcot_pkg::QPROD_W-1:ntcot_pkg::RECIP_SHIFT];
        // truncation toward zero: divide the magnitude, then restore the sign
        deg      = neg ? -$signed(ntcot_pkg::DEG_W'(quot)) : $signed(ntcot_pkg::DEG_W'(quot));
        limit_s  = $signed({2'b00, temp_limit_reg});
        over     = (temp_limit_reg != '0) && ($signed({deg[ntcot_pkg::DEG_W-1], deg}) > limit_s);

        if (!over) begin
            streak_next = '0;
        end else if (streak_reg == ntcot_pkg::STREAK_MAX) begin
            streak_next = streak_reg;
        end else begin
            streak_next = streak_reg + 1'b1;
        end
        trip       = over && (streak_next > trip_count_reg);
        pulse      = trip && !fault_reg;
        fault_next = fault_reg || trip;
    end

    logic signed [ntcot_pkg::DEG_W-1:0] deg_reg;
    logic                               over_reg;
    logic                               pulse_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            streak_reg <= '0;
            fault_reg  <= 1'b0;
        end else if (out_adv && mid_valid_reg) begin
            streak_reg <= streak_next;
            fault_reg  <= fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && mid_valid_reg) begin
            deg_reg   <= deg;
            over_reg  <= over;
            pulse_reg <= pulse;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, pulse_reg, fault_reg, over_reg, deg_reg};

endmodule

// ===== tb/tb_ntc_overtemp_monitor_unit.sv =====
`timescale 1ns / 100ps

module tb_ntc_overtemp_monitor_unit;
    import ntcot_pkg::*;

    localparam int MAX_CYCLES = 500000;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic signed [8:0] deg;
        logic              over;
        logic              fault;
        logic              alarm;
    } reading_t;

    class reading_scoreboard;
        logic [REG_W-1:0] temp_limit;
        logic [REG_W-1:0] trip_count;
        logic [REG_W-1:0] over_streak;
        bit               fault_set;
        reading_t         pending_q[$];
        int               errors;
        int               checked;
        int               overs;
        int               alarms;

        function new();
            temp_limit  = '0;
            trip_count  = REG_W'(5);
            over_streak = '0;
            fault_set   = 1'b0;
            errors      = 0;
            checked     = 0;
            overs       = 0;
            alarms      = 0;
        endfunction

        // table points in tenths of a degree, falling with the sample value
        static function int table_point(int idx);
            case (idx)
                0:  return 1835;
                1:  return 1493;
                2:  return 1151;
                3:  return 969;
                4:  return 847;
                5:  return 754;
                6:  return 678;
                7:  return 615;
                8:  return 560;
                9:  return 511;
                10: return 466;
                11: return 425;
                12: return 386;
                13: return 350;
                14: return 316;
                15: return 282;
                16: return 250;
                17: return 218;
                18: return 187;
                19: return 156;
                20: return 125;
                21: return 93;
                22: return 61;
                23: return 28;
                24: return -6;
                25: return -43;
                26: return -83;
                27: return -126;
                28: return -176;
                29: return -235;
                30: return -311;
                31: return -428;
                default: return -545;
            endcase
        endfunction

        static function int degrees_of(logic [11:0] smp);
            int seg;
            int frac;
            int lo;
            int hi;
            int tenths;
            seg    = smp[11:7];
            frac   = smp[6:0];
            lo     = table_point(seg);
            hi     = table_point(seg + 1);
            tenths = lo - ((lo - hi) * frac) / 128;
            // int division truncates toward zero
            return tenths / 10;
        endfunction

        function bit is_hot(logic [11:0] smp);
            int lim;
            lim = temp_limit;
            return (lim != 0) && (degrees_of(smp) > lim);
        endfunction

        function void set_reg(cfg_index_t idx, logic [REG_W-1:0] val);
            case (idx)
                CFG_TEMP_LIMIT: temp_limit = val;
                CFG_TRIP_COUNT: trip_count = val;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [11:0] smp);
            reading_t r;
            bit       hot;
            hot     = is_hot(smp);
            r.deg   = 9'(degrees_of(smp));
            r.over  = hot;
            r.alarm = 1'b0;
            if (hot) begin
                if (over_streak != 8'hFF) begin
                    over_streak = over_streak + 8'd1;
                end
                if (over_streak > trip_count) begin
                    r.alarm   = !fault_set;
                    fault_set = 1'b1;
                end
            end else begin
                over_streak = '0;
            end
            r.fault = fault_set;
            pending_q.push_back(r);
        endfunction

        function void field_check(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_reading(logic [M_DATA_W-1:0] beat);
            reading_t exp_r;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, beat);
                return;
            end
            exp_r = pending_q.pop_front();
            checked++;
            if (beat[9]) overs++;
            if (beat[11]) alarms++;
            field_check("temperature_deg", exp_r.deg, $signed(beat[8:0]));
            field_check("over_limit", exp_r.over, beat[9]);
            field_check("fault_latched", exp_r.fault, beat[10]);
            field_check("alarm_pulse", exp_r.alarm, beat[11]);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wen = 1'b0;
    cfg_index_t            cfg_index = CFG_TEMP_LIMIT;
    logic [REG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    reading_scoreboard sb = new();
    int src_idle_pct = 9;
    int snk_idle_pct = 81;
    int samples_sent = 0;
    int settings_used = 1;
    int cycles = 0;

    ntc_overtemp_monitor_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: check every accepted beat, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_reading(m_tdata);
        end
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    task automatic send_sample(logic [11:0] smp);
        // idle pattern swaps by thirds of the run
        if (samples_sent == 650) begin
            src_idle_pct = 81;
            snk_idle_pct = 9;
        end else if (samples_sent == 1300) begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, smp};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(smp);
        samples_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [REG_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    function automatic logic [11:0] pick_sample(bit want_hot);
        logic [11:0] smp;
        smp = 12'($urandom);
        for (int k = 0; k < 200; k++) begin
            if (sb.is_hot(smp) == want_hot) return smp;
            smp = want_hot ? 12'($urandom_range(0, 1535)) : 12'($urandom);
        end
        return smp;
    endfunction

    // over-limit runs of random length, each closed by a good sample,
    // with some plain random samples mixed in
    task automatic run_phase(logic [REG_W-1:0] lim, logic [REG_W-1:0] trip,
                             int n, int run_lo, int run_hi);
        int sent;
        int len;
        settle();
        write_reg(CFG_TEMP_LIMIT, lim);
        write_reg(CFG_TRIP_COUNT, trip);
        cfg_wen <= 1'b0;
        settings_used++;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 4) != 0) begin
                len = $urandom_range(run_lo, run_hi);
                for (int k = 0; k < len && sent < n; k++) begin
                    send_sample(pick_sample(1'b1));
                    sent++;
                end
                if (sent < n) begin
                    send_sample(pick_sample(1'b0));
                    sent++;
                end
            end else begin
                send_sample(12'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        logic [11:0] directed_q[$];
        logic [REG_W-1:0] rnd_trip;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values: check off, only temperatures matter
        directed_q = '{12'h000, 12'hFFF, 12'h07F, 12'h080, 12'hF80, 12'hBFF,
                       12'hC00, 12'h555, 12'hAAA};
        for (int b = 0; b < 12; b++) directed_q.push_back(12'(1 << b));
        foreach (directed_q[i]) send_sample(directed_q[i]);

        // limit above any temperature, trip at zero
        run_phase(8'd255, 8'd0, 150, 1, 8);
        // long runs saturate the streak; trip at 255 can never fire
        run_phase(8'd1, 8'd255, 330, 260, 300);
        run_phase(8'd60, 8'd254, 250, 1, 20);
        // check disabled
        run_phase(8'd0, 8'd0, 120, 1, 5);
        // fault latches here, then stays set
        run_phase(8'd40, 8'd12, 350, 1, 16);
        run_phase(8'd120, 8'd3, 200, 1, 6);
        rnd_trip = REG_W'($urandom_range(0, 30));
        run_phase(REG_W'($urandom_range(1, 182)), rnd_trip, 430, 1, rnd_trip + 4);
        run_phase(8'd183, 8'd1, 100, 1, 4);

        settle();
        $display("checked %0d readings over %0d register settings",
                 sb.checked, settings_used);
        $display("%0d over-limit readings, %0d alarm beats, %0d errors",
                 sb.overs, sb.alarms, sb.errors);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
